### rtl/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types, constants and calendar functions for the expiry date pipeline.
// ----------------------------------------------------------------------------
package dam_pkg;

	localparam int DayW   = 5;
	localparam int MonthW = 4;
	localparam int YearW  = 14;
	localparam int ShelfW = 12;
	localparam int CfgW   = 14;

	// Reciprocals for division by 12 and by 100. They are exact over the input ranges.
	localparam logic [11:0] Recip12  = 12'd2731;
	localparam int          Shift12  = 15;
	localparam logic [13:0] Recip100 = 14'd10486;
	localparam int          Shift100 = 20;

	localparam logic [MonthW-1:0] MonthsPerYear = 4'd12;
	localparam logic [YearW-1:0]  YearMax       = 14'd9999;

	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthApr = 4'd4;
	localparam logic [MonthW-1:0] MonthJun = 4'd6;
	localparam logic [MonthW-1:0] MonthSep = 4'd9;
	localparam logic [MonthW-1:0] MonthNov = 4'd11;

	localparam logic [DayW-1:0] LenFebCommon = 5'd28;
	localparam logic [DayW-1:0] LenFebLeap   = 5'd29;
	localparam logic [DayW-1:0] LenShort     = 5'd30;
	localparam logic [DayW-1:0] LenLong      = 5'd31;

	typedef enum logic [1:0] {
		REG_TODAY_DAY   = 2'd0,
		REG_TODAY_MONTH = 2'd1,
		REG_TODAY_YEAR  = 2'd2
	} dam_reg_t;

	typedef struct packed {
		logic [DayW-1:0]   day;
		logic [MonthW-1:0] month;
		logic [YearW-1:0]  year;
	} dam_date_t;

	typedef struct packed {
		dam_date_t         date;
		logic [ShelfW-1:0] shelf;
	} dam_item_t;

	typedef struct packed {
		logic      ok;
		dam_date_t date;
	} dam_res_t;

	// The quotient y / 100 comes in precomputed; y % 400 is zero when both
	// y % 100 and (y / 100) % 4 are zero.
	function automatic logic is_leap(input logic [YearW-1:0] y, input logic [7:0] q100);
		logic [YearW:0] r100;
		r100 = {1'b0, y} - (15'(q100) * 15'd100);
		return ((y[1:0] == 2'd0) && (r100 != '0)) || ((r100 == '0) && (q100[1:0] == 2'd0));
	endfunction

	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] len;
		if (m == MonthFeb) begin
			len = leap ? LenFebLeap : LenFebCommon;
		end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
			len = LenShort;
		end else begin
			len = LenLong;
		end
		return len;
	endfunction

endpackage

### rtl/dam_month_add.sv
// ----------------------------------------------------------------------------
// dam_month_add
// Stages one and two: reciprocal products, date validity check and month add
// with carry of whole years.
// ----------------------------------------------------------------------------
module dam_month_add (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dam_pkg::dam_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output dam_pkg::dam_res_t  out_res
);
	import dam_pkg::*;

	logic              vld_s1;
	dam_item_t         item_s1;
	logic [23:0]       p12_s1;
	logic [27:0]       p100_s1;
	logic              vld_s2;
	dam_res_t          res_s2;
	logic              rdy_s1;
	logic              rdy_s2;

	logic [8:0]        q12;
	logic [3:0]        r12;
	logic [7:0]        q100;
	logic              leap;
	logic [DayW-1:0]   len;
	logic              ok;
	logic [4:0]        m_sum;
	logic [YearW-1:0]  y_sum;
	dam_res_t          res_d;

	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			item_s1 <= in_item;
			p12_s1  <= 24'(in_item.shelf) * 24'(Recip12);
			p100_s1 <= 28'(in_item.date.year) * 28'(Recip100);
		end
		if (rdy_s2 && vld_s1) begin
			res_s2 <= res_d;
		end
	end

	always_comb begin
		q12   = p12_s1[Shift12 +: 9];
		r12   = 4'(item_s1.shelf - (12'(q12) * 12'(MonthsPerYear)));
		q100  = p100_s1[Shift100 +: 8];
		leap  = is_leap(item_s1.date.year, q100);
		len   = month_len(item_s1.date.month, leap);
		ok    = (item_s1.date.year != '0) && (item_s1.date.year <= YearMax) &&
		        (item_s1.date.month != '0) && (item_s1.date.month <= MonthsPerYear) &&
		        (item_s1.date.day != '0) && (item_s1.date.day <= len);
		m_sum = 5'(item_s1.date.month) + 5'(r12);
		y_sum = item_s1.date.year + YearW'(q12);
		res_d.ok       = ok;
		res_d.date.day = item_s1.date.day;
		if (m_sum > 5'(MonthsPerYear)) begin
			res_d.date.month = 4'(m_sum - 5'(MonthsPerYear));
			res_d.date.year  = y_sum + 14'd1;
		end else begin
			res_d.date.month = 4'(m_sum);
			res_d.date.year  = y_sum;
		end
	end

	assign out_valid = vld_s2;
	assign out_res   = res_s2;

endmodule

### rtl/dam_day_roll.sv
// ----------------------------------------------------------------------------
// dam_day_roll
// Stages three and four: leap test of the target year and roll of excess days
// into the following month.
// ----------------------------------------------------------------------------
module dam_day_roll (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  dam_pkg::dam_res_t in_res,
	output logic             out_valid,
	input  logic             out_ready,
	output dam_pkg::dam_res_t out_res
);
	import dam_pkg::*;

	logic            vld_s3;
	dam_res_t        res_s3;
	logic [27:0]     p100_s3;
	logic            vld_s4;
	dam_res_t        res_s4;
	logic            rdy_s3;
	logic            rdy_s4;

	logic [7:0]      q100;
	logic            leap;
	logic [DayW-1:0] len;
	dam_res_t        res_d;

	assign rdy_s4   = !vld_s4 || out_ready;
	assign rdy_s3   = !vld_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s3) vld_s3 <= in_valid;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			res_s3  <= in_res;
			p100_s3 <= 28'(in_res.date.year) * 28'(Recip100);
		end
		if (rdy_s4 && vld_s3) begin
			res_s4 <= res_d;
		end
	end

	// December has 31 days, so a roll never moves past the end of the year.
	always_comb begin
		q100  = p100_s3[Shift100 +: 8];
		leap  = is_leap(res_s3.date.year, q100);
		len   = month_len(res_s3.date.month, leap);
		res_d = res_s3;
		if (res_s3.date.day > len) begin
			res_d.date.day   = res_s3.date.day - len;
			res_d.date.month = res_s3.date.month + 4'd1;
		end
	end

	assign out_valid = vld_s4;
	assign out_res   = res_s4;

endmodule

### rtl/dam_expiry_cmp.sv
// ----------------------------------------------------------------------------
// dam_expiry_cmp
// Stage five: comparison with today's date and clearing of invalid results.
// ----------------------------------------------------------------------------
module dam_expiry_cmp (
	input  logic              clk,
	input  logic              arst_n,
	input  dam_pkg::dam_date_t today,
	input  logic              in_valid,
	output logic              in_ready,
	input  dam_pkg::dam_res_t  in_res,
	output logic              out_valid,
	input  logic              out_ready,
	output dam_pkg::dam_res_t  out_res,
	output logic              out_in_date
);
	import dam_pkg::*;

	logic     vld_s5;
	dam_res_t res_s5;
	logic     in_date_s5;
	logic     rdy_s5;

	assign rdy_s5   = !vld_s5 || out_ready;
	assign in_ready = rdy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (rdy_s5) begin
			vld_s5 <= in_valid;
		end
	end

	// Concatenating year, month and day, in that order, makes one compare an
	// ordering on the whole date.
	always_ff @(posedge clk) begin
		if (rdy_s5 && in_valid) begin
			if (in_res.ok) begin
				res_s5     <= in_res;
				in_date_s5 <= {in_res.date.year, in_res.date.month, in_res.date.day} >=
				              {today.year, today.month, today.day};
			end else begin
				res_s5     <= '0;
				in_date_s5 <= 1'b0;
			end
		end
	end

	assign out_valid   = vld_s5;
	assign out_res     = res_s5;
	assign out_in_date = in_date_s5;

endmodule

### rtl/date_add_months_expiry_check_core.sv
// ----------------------------------------------------------------------------
// date_add_months_expiry_check_core
// Adds a shelf life in months to a production date and checks the expiry
// date against today's date.
// ----------------------------------------------------------------------------
// The core takes one beat per clock cycle while the output is not stalled
// and returns one result beat for each input beat, in order. Each beat
// passes through five pipeline stages: reciprocal products, validity check
// with month add, leap product of the target year, day roll, and the final
// comparison. An invalid production date gives a zero date with both flags
// clear. The user must write today's date through the configuration port
// only while no beat is in flight; the core itself does not enforce this.
module date_add_months_expiry_check_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [1:0]               cfg_idx,
	input  logic [dam_pkg::CfgW-1:0] cfg_wr_data,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	// prod_day[4:0], prod_month[8:5], prod_year[22:9], shelf_months[34:23], zero pad
	input  logic [39:0]              s_axis_tdata,
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	// exp_day[4:0], exp_month[8:5], exp_year[22:9], in_date[23]
	output logic [23:0]              m_axis_tdata,
	// date_ok[0]
	output logic                     m_axis_tuser
);
	import dam_pkg::*;

	dam_date_t today_q;
	dam_item_t in_item;
	logic      add_valid;
	logic      add_ready;
	dam_res_t  add_res;
	logic      roll_valid;
	logic      roll_ready;
	dam_res_t  roll_res;
	dam_res_t  fin_res;
	logic      fin_in_date;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			today_q.day   <= 5'd1;
			today_q.month <= 4'd1;
			today_q.year  <= 14'd2001;
		end else if (cfg_wr_en) begin
			unique case (cfg_idx)
				REG_TODAY_DAY:   today_q.day   <= cfg_wr_data[DayW-1:0];
				REG_TODAY_MONTH: today_q.month <= cfg_wr_data[MonthW-1:0];
				REG_TODAY_YEAR:  today_q.year  <= cfg_wr_data[YearW-1:0];
				default: ;
			endcase
		end
	end

	assign in_item.date.day   = s_axis_tdata[4:0];
	assign in_item.date.month = s_axis_tdata[8:5];
	assign in_item.date.year  = s_axis_tdata[22:9];
	assign in_item.shelf      = s_axis_tdata[34:23];

	dam_month_add u_month_add (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.out_valid (add_valid),
		.out_ready (add_ready),
		.out_res   (add_res)
	);

	dam_day_roll u_day_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (add_valid),
		.in_ready  (add_ready),
		.in_res    (add_res),
		.out_valid (roll_valid),
		.out_ready (roll_ready),
		.out_res   (roll_res)
	);

	dam_expiry_cmp u_expiry_cmp (
		.clk         (clk),
		.arst_n      (arst_n),
		.today       (today_q),
		.in_valid    (roll_valid),
		.in_ready    (roll_ready),
		.in_res      (roll_res),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (fin_res),
		.out_in_date (fin_in_date)
	);

	assign m_axis_tdata = {fin_in_date, fin_res.date.year, fin_res.date.month, fin_res.date.day};
	assign m_axis_tuser = fin_res.ok;

endmodule
